// ----- hw/rtl/rcs_pkg.sv -----
// Package: shared types, codes and constants of the rejection coefficient sampler.
`timescale 1ns / 1ps
package rcs_pkg;

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int VALUE_W   = 17;
   localparam int INDEX_W   = 10;
   localparam int COUNT_W   = 11;
   localparam int MODE_W    = 2;
   localparam int STEP_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 17;

   // Default upper limit on the coefficient target
   localparam int MAX_COEFS_DEFAULT = 1024;

   // Sampling modes
   localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ETA1    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ETA2    = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_BOUND     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TARGET = 2'd2;

   // Register reset values
   localparam logic [MODE_W-1:0]  SAMPLE_MODE_RESET = MODE_ETA1;
   localparam logic [VALUE_W-1:0] Q_BOUND_RESET     = 17'h10000;
   localparam int                 COEF_TARGET_RESET = 256;

   // Eta-1: bytes at or above this are rejected; last base-3 digit index
   localparam logic [BYTE_W-1:0] ETA1_LIMIT     = 8'd243;
   localparam logic [STEP_W-1:0] ETA1_LAST_STEP = 3'd4;

   // Division by 3 of a byte: (x * 171) >> 9
   localparam logic [7:0] DIV3_MUL   = 8'd171;
   localparam int         DIV3_SHIFT = 9;

   // Division by 5 of a nibble: (x * 205) >> 10
   localparam logic [7:0] DIV5_MUL   = 8'd205;
   localparam int         DIV5_SHIFT = 10;

   // Eta-2: rejected nibble value
   localparam logic [3:0] NIB_REJECT = 4'hF;

   // One result item
   typedef struct packed {
      logic signed [VALUE_W-1:0] coef_value;
      logic                      coef_valid;
      logic [INDEX_W-1:0]        coef_index;
      logic [COUNT_W-1:0]        sampled_count;
      logic                      target_reached;
      logic                      run_last;
   } rsp_type;

   // Outcome of one step of the shared sampling unit
   typedef struct packed {
      logic                      emit;
      logic                      done;
      logic signed [VALUE_W-1:0] value;
      logic [BYTE_W-1:0]         work_next;
      logic                      hold_set;
      logic                      hold_clear;
   } step_res_type;

endpackage

// ----- hw/rtl/rcs_if.sv -----
// Interfaces: request, response and register-write channels of the sampler.
`timescale 1ns / 1ps
interface rcs_req_if;
   logic                    valid;
   logic                    ready;
   logic [rcs_pkg::BYTE_W-1:0] rand_byte;
   logic                    start_new;
   logic                    end_of_buffer;

   modport source (output valid, output rand_byte, output start_new,
                   output end_of_buffer, input ready);
   modport sink   (input valid, input rand_byte, input start_new,
                   input end_of_buffer, output ready);
endinterface

interface rcs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rcs_pkg::VALUE_W-1:0] coef_value;
   logic                              coef_valid;
   logic [rcs_pkg::INDEX_W-1:0]       coef_index;
   logic [rcs_pkg::COUNT_W-1:0]       sampled_count;
   logic                              target_reached;
   logic                              run_last;

   modport source (output valid, output coef_value, output coef_valid,
                   output coef_index, output sampled_count,
                   output target_reached, output run_last, input ready);
   modport sink   (input valid, input coef_value, input coef_valid,
                   input coef_index, input sampled_count,
                   input target_reached, input run_last, output ready);
endinterface

interface rcs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rcs_pkg::CSR_IDX_W-1:0]  index;
   logic [rcs_pkg::CSR_DAT_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/rejection_coefficient_sampler.sv -----
// Top level: rejection coefficient sampler with sequencer and output register.
// Each byte is accepted in idle, takes 1 to 5 unit steps and is then flushed;
// a new byte is taken only after the last one is flushed. The shared step unit
// produces at most one coefficient per cycle while the output register is free.
// A stalled response port holds the sequencer until the output register frees.
// Reset (synchronous): counter and pairing cleared, registers to defaults.
`timescale 1ns / 1ps
module rejection_coefficient_sampler #(
   parameter int MAX_COEFS = rcs_pkg::MAX_COEFS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   rcs_req_if.sink   req_ch,
   rcs_rsp_if.source rsp_ch,
   rcs_csr_if.sink   csr_ch
);
   import rcs_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [MODE_W-1:0]  sample_mode;
   logic [VALUE_W-1:0] q_bound;
   logic [COUNT_W-1:0] eff_target;
   step_res_type       step_res;

   logic [1:0]         state_ff, state_in;
   logic [BYTE_W-1:0]  work_ff, work_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               eob_ff, eob_in;
   logic [COUNT_W-1:0] counter_ff, counter_in;
   logic [BYTE_W-1:0]  held_ff, held_in;
   logic               hold_ff, hold_in;
   rsp_type            pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_accept;
   logic               out_free;
   logic [COUNT_W-1:0] counter_inc;

   rcs_csr #(.MAX_COEFS(MAX_COEFS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_ch      (csr_ch),
      .sample_mode (sample_mode),
      .q_bound     (q_bound),
      .eff_target  (eff_target)
   );

   rcs_step_unit u_step (
      .sample_mode (sample_mode),
      .step_idx    (step_ff),
      .work        (work_ff),
      .held_byte   (held_ff),
      .byte_held   (hold_ff),
      .q_bound     (q_bound),
      .counter     (counter_ff),
      .target      (eff_target),
      .res         (step_res)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && !reset;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign counter_inc  = counter_ff + COUNT_W'(1);

   // Sequencer: accept a byte, step the shared unit, then flush the last item
   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      step_in       = step_ff;
      eob_in        = eob_ff;
      counter_in    = counter_ff;
      held_in       = held_ff;
      hold_in       = hold_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               work_in  = req_ch.rand_byte;
               eob_in   = req_ch.end_of_buffer;
               step_in  = '0;
               state_in = S_RUN;
               if (req_ch.start_new) begin
                  counter_in = '0;
                  held_in    = '0;
                  hold_in    = 1'b0;
               end
            end
         end
         S_RUN: begin
            if (out_free) begin
               work_in = step_res.work_next;
               step_in = step_ff + STEP_W'(1);
               if (step_res.hold_set) begin
                  held_in = work_ff;
                  hold_in = 1'b1;
               end
               if (step_res.hold_clear) begin
                  held_in = '0;
                  hold_in = 1'b0;
               end
               if (step_res.emit) begin
                  // previous coefficient is known not to be the last one
                  if (pend_valid_ff) begin
                     rsp_in       = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  counter_in             = counter_inc;
                  pend_in.coef_value     = step_res.value;
                  pend_in.coef_valid     = 1'b1;
                  pend_in.coef_index     = counter_ff[INDEX_W-1:0];
                  pend_in.sampled_count  = counter_inc;
                  pend_in.target_reached = (counter_inc >= eff_target);
                  pend_in.run_last       = 1'b0;
                  pend_valid_in          = 1'b1;
               end
               if (step_res.done) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               if (pend_valid_ff) begin
                  rsp_in          = pend_ff;
                  rsp_in.run_last = 1'b1;
                  rsp_valid_in    = 1'b1;
               end else if (eob_ff) begin
                  rsp_in.coef_value     = '0;
                  rsp_in.coef_valid     = 1'b0;
                  rsp_in.coef_index     = '0;
                  rsp_in.sampled_count  = counter_ff;
                  rsp_in.target_reached = (counter_ff >= eff_target);
                  rsp_in.run_last       = 1'b1;
                  rsp_valid_in          = 1'b1;
               end
               if (eob_ff) begin
                  held_in = '0;
                  hold_in = 1'b0;
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         counter_ff    <= '0;
         held_ff       <= '0;
         hold_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         eob_ff        <= 1'b0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         counter_ff    <= counter_in;
         held_ff       <= held_in;
         hold_ff       <= hold_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         eob_ff        <= eob_in;
         step_ff       <= step_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // Response port
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.coef_value     = rsp_ff.coef_value;
   assign rsp_ch.coef_valid     = rsp_ff.coef_valid;
   assign rsp_ch.coef_index     = rsp_ff.coef_index;
   assign rsp_ch.sampled_count  = rsp_ff.sampled_count;
   assign rsp_ch.target_reached = rsp_ff.target_reached;
   assign rsp_ch.run_last       = rsp_ff.run_last;

   // No coefficient may linger in the pending slot between bytes
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending coefficient left while idle");

   // A coefficient item counts itself: index is the count before it
   a_index_matches_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.coef_valid) |->
      (rsp_ff.sampled_count[INDEX_W-1:0] == rsp_ff.coef_index + INDEX_W'(1)))
      else $error("coefficient index and count disagree");

   // A status item always closes its byte
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.coef_valid) |-> rsp_ff.run_last)
      else $error("status item not marked last");

   // The counter moves only while a byte is in work
   a_counter_idle_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_accept) |=> $stable(counter_ff))
      else $error("counter changed while idle");

endmodule

// ----- hw/rtl/rcs_csr.sv -----
// Configuration registers: mode, uniform bound and clamped coefficient target.
`timescale 1ns / 1ps
module rcs_csr #(
   parameter int MAX_COEFS = rcs_pkg::MAX_COEFS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   rcs_csr_if.sink                      csr_ch,
   output logic [rcs_pkg::MODE_W-1:0]   sample_mode,
   output logic [rcs_pkg::VALUE_W-1:0]  q_bound,
   output logic [rcs_pkg::COUNT_W-1:0]  eff_target
);
   import rcs_pkg::*;

   localparam logic [COUNT_W-1:0] TARGET_RESET =
      (COEF_TARGET_RESET > MAX_COEFS) ? COUNT_W'(MAX_COEFS) : COUNT_W'(COEF_TARGET_RESET);

   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [VALUE_W-1:0] bound_ff, bound_in;
   logic [COUNT_W-1:0] target_ff, target_in;
   logic [COUNT_W-1:0] wr_target;
   logic               wr_en;

   assign csr_ch.ready = !reset;
   assign wr_en        = csr_ch.valid && csr_ch.ready;
   assign wr_target    = csr_ch.data[COUNT_W-1:0];

   // Register writes; the target is clamped once when written
   always_comb begin
      mode_in   = mode_ff;
      bound_in  = bound_ff;
      target_in = target_ff;
      if (wr_en) begin
         case (csr_ch.index)
            CSR_SAMPLE_MODE: mode_in  = csr_ch.data[MODE_W-1:0];
            CSR_Q_BOUND:     bound_in = csr_ch.data[VALUE_W-1:0];
            CSR_COEF_TARGET: begin
               target_in = (32'(wr_target) > MAX_COEFS) ? COUNT_W'(MAX_COEFS) : wr_target;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= SAMPLE_MODE_RESET;
         bound_ff  <= Q_BOUND_RESET;
         target_ff <= TARGET_RESET;
      end else begin
         mode_ff   <= mode_in;
         bound_ff  <= bound_in;
         target_ff <= target_in;
      end
   end

   assign sample_mode = mode_ff;
   assign q_bound     = bound_ff;
   assign eff_target  = target_ff;

endmodule

// ----- hw/rtl/rcs_step_unit.sv -----
// Shared sampling unit: one pairing, base-3 digit or nibble step per cycle while the sequencer is not held.
`timescale 1ns / 1ps
module rcs_step_unit (
   input  logic [rcs_pkg::MODE_W-1:0]  sample_mode,
   input  logic [rcs_pkg::STEP_W-1:0]  step_idx,
   input  logic [rcs_pkg::BYTE_W-1:0]  work,
   input  logic [rcs_pkg::BYTE_W-1:0]  held_byte,
   input  logic                        byte_held,
   input  logic [rcs_pkg::VALUE_W-1:0] q_bound,
   input  logic [rcs_pkg::COUNT_W-1:0] counter,
   input  logic [rcs_pkg::COUNT_W-1:0] target,
   output rcs_pkg::step_res_type       res
);
   import rcs_pkg::*;

   logic [15:0]        prod3;
   logic [BYTE_W-1:0]  quot3;
   logic [1:0]         rem3;
   logic [3:0]         nib;
   logic [11:0]        prod5;
   logic [1:0]         quot5;
   logic [2:0]         rem5;
   logic [VALUE_W-1:0] pair;

   // Digit arithmetic by reciprocal multiplication
   always_comb begin
      prod3 = 16'(work) * 16'(DIV3_MUL);
      quot3 = BYTE_W'(prod3 >> DIV3_SHIFT);
      rem3  = 2'(work - 8'(quot3 * 8'd3));
      nib   = (step_idx == '0) ? work[3:0] : work[7:4];
      prod5 = 12'(nib) * 12'(DIV5_MUL);
      quot5 = 2'(prod5 >> DIV5_SHIFT);
      rem5  = 3'(nib - 4'(quot5) * 4'd5);
      pair  = {1'b0, work, held_byte};
   end

   // Step outcome per mode
   always_comb begin
      res            = '0;
      res.work_next  = work;
      if (counter >= target) begin
         res.done = 1'b1;
      end else begin
         case (sample_mode)
            MODE_UNIFORM: begin
               res.done = 1'b1;
               if (byte_held) begin
                  res.hold_clear = 1'b1;
                  res.emit       = (pair < q_bound);
                  res.value      = pair;
               end else begin
                  res.hold_set = 1'b1;
               end
            end
            MODE_ETA1: begin
               if (step_idx == '0 && work >= ETA1_LIMIT) begin
                  res.done = 1'b1;
               end else begin
                  res.emit      = 1'b1;
                  res.value     = (rem3 == 2'd2) ? -VALUE_W'(1) : VALUE_W'(rem3);
                  res.work_next = quot3;
                  res.done      = (step_idx == ETA1_LAST_STEP);
               end
            end
            MODE_ETA2: begin
               res.emit  = (nib != NIB_REJECT);
               res.value = VALUE_W'(2) - VALUE_W'(rem5);
               res.done  = (step_idx != '0);
            end
            default: res.done = 1'b1;
         endcase
      end
   end

endmodule

// ----- tb/rejection_coefficient_sampler_test.sv -----
// Testbench: feeds directed bytes and random byte buffers to the sampler and checks each result item.
`timescale 1ns / 1ps
module rejection_coefficient_sampler_test;
   import rcs_pkg::*;

   localparam int CLOCK_HALF   = 6;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_STALL   = 400;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 50;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] rand_byte;
      logic              start_new;
      logic              end_of_buffer;
   } byte_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rcs_req_if req_ch();
   rcs_rsp_if rsp_ch();
   rcs_csr_if csr_ch();

   rejection_coefficient_sampler u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Sampler state as the checker sees it
   logic [MODE_W-1:0] cfg_mode   = SAMPLE_MODE_RESET;
   int unsigned       cfg_bound  = Q_BOUND_RESET;
   int unsigned       cfg_target = COEF_TARGET_RESET;
   int unsigned       coef_count = 0;
   logic [BYTE_W-1:0] low_byte   = '0;
   logic              low_held   = 1'b0;

   byte_item_type pending_bytes[$];
   rsp_type    coef_results[$];
   logic       req_offered   = 1'b0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   logic       stall_armed   = 1'b0;
   int         stall_cycles  = 0;
   int         errors        = 0;
   int         cycle_count   = 0;

   // Settings of the random phases; both bound extremes and the largest target among them
   logic [MODE_W-1:0] phase_mode [PHASES] = '{MODE_UNIFORM, MODE_ETA1, MODE_ETA2, MODE_UNIFORM,
                                              MODE_ETA2, MODE_ETA1, MODE_UNIFORM, MODE_ETA2};
   int unsigned phase_bound  [PHASES] = '{65536, 3329, 1, 131071, 0, 65535, 12289, 40000};
   int unsigned phase_target [PHASES] = '{256, 1024, 37, 2047, 1, 500, 64, 128};

   always #CLOCK_HALF clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // One coefficient item; the counter moves past it
   function automatic void push_coef(input int val, input int unsigned goal);
      rsp_type r;
      r = '0;
      r.coef_value     = val[VALUE_W-1:0];
      r.coef_valid     = 1'b1;
      r.coef_index     = coef_count[INDEX_W-1:0];
      coef_count++;
      r.sampled_count  = coef_count[COUNT_W-1:0];
      r.target_reached = (coef_count >= goal);
      coef_results.push_back(r);
   endfunction

   // Expected result items of one accepted byte
   function automatic void predict_byte(input byte_item_type it);
      int unsigned goal;
      int unsigned t;
      int unsigned nib;
      int          first;
      rsp_type     r;
      first = coef_results.size();
      if (it.start_new) begin
         coef_count = 0;
         low_byte   = '0;
         low_held   = 1'b0;
      end
      goal = (cfg_target > MAX_COEFS_DEFAULT) ? MAX_COEFS_DEFAULT : cfg_target;
      if (coef_count < goal) begin
         case (cfg_mode)
            MODE_UNIFORM: begin
               if (!low_held) begin
                  low_byte = it.rand_byte;
                  low_held = 1'b1;
               end else begin
                  t = {it.rand_byte, low_byte};
                  low_held = 1'b0;
                  low_byte = '0;
                  if (t < cfg_bound) push_coef(t, goal);
               end
            end
            MODE_ETA1: begin
               // five base-3 digits, low first; digit 2 maps to -1
               if (it.rand_byte < ETA1_LIMIT) begin
                  t = it.rand_byte;
                  for (int k = 0; k < 5 && coef_count < goal; k++) begin
                     push_coef((t % 3 == 2) ? -1 : int'(t % 3), goal);
                     t = t / 3;
                  end
               end
            end
            MODE_ETA2: begin
               nib = it.rand_byte[3:0];
               if (nib != NIB_REJECT) push_coef(2 - int'(nib % 5), goal);
               nib = it.rand_byte[7:4];
               if (nib != NIB_REJECT && coef_count < goal) push_coef(2 - int'(nib % 5), goal);
            end
            default: ;
         endcase
      end
      // end of buffer drops a held byte; a status item if nothing came out
      if (it.end_of_buffer) begin
         low_held = 1'b0;
         low_byte = '0;
         if (coef_results.size() == first) begin
            r = '0;
            r.sampled_count  = coef_count[COUNT_W-1:0];
            r.target_reached = (coef_count >= goal);
            coef_results.push_back(r);
         end
      end
      if (coef_results.size() > first) begin
         r = coef_results.pop_back();
         r.run_last = 1'b1;
         coef_results.push_back(r);
      end
   endfunction

   // Request side: retire the accepted item
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         predict_byte(pending_bytes[0]);
         pending_bytes.delete(0);
         req_offered = 1'b0;
      end
   end

   // Request side: offer the next item, held until taken
   always @(negedge clock) begin
      if (!req_offered) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.rand_byte     <= pending_bytes[0].rand_byte;
            req_ch.start_new     <= pending_bytes[0].start_new;
            req_ch.end_of_buffer <= pending_bytes[0].end_of_buffer;
            req_ch.valid         <= 1'b1;
            req_offered = 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result side: compare against the oldest expected item
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (coef_results.size() == 0) begin
            $error("unexpected item: coef_value %0d coef_valid %0b sampled_count %0d",
                   rsp_ch.coef_value, rsp_ch.coef_valid, rsp_ch.sampled_count);
            errors++;
         end else begin
            want = coef_results.pop_front();
            if (rsp_ch.coef_value !== want.coef_value) begin
               $error("coef_value: expected %0d, got %0d", want.coef_value, rsp_ch.coef_value);
               errors++;
            end
            if (rsp_ch.coef_valid !== want.coef_valid) begin
               $error("coef_valid: expected %0b, got %0b", want.coef_valid, rsp_ch.coef_valid);
               errors++;
            end
            if (rsp_ch.coef_index !== want.coef_index) begin
               $error("coef_index: expected %0d, got %0d", want.coef_index, rsp_ch.coef_index);
               errors++;
            end
            if (rsp_ch.sampled_count !== want.sampled_count) begin
               $error("sampled_count: expected %0d, got %0d", want.sampled_count,
                      rsp_ch.sampled_count);
               errors++;
            end
            if (rsp_ch.target_reached !== want.target_reached) begin
               $error("target_reached: expected %0b, got %0b", want.target_reached,
                      rsp_ch.target_reached);
               errors++;
            end
            if (rsp_ch.run_last !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_ch.run_last);
               errors++;
            end
         end
      end
   end

   // Result side: random back-pressure, plus the long hold-off
   always @(negedge clock) begin
      rsp_ch.ready <= !stall_armed && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(negedge clock) begin
      if (stall_armed) begin
         stall_cycles++;
         if (stall_cycles >= LONG_STALL) stall_armed = 1'b0;
      end
   end

   task automatic send(input logic [BYTE_W-1:0] b, input logic st, input logic eob);
      byte_item_type it;
      it.rand_byte     = b;
      it.start_new     = st;
      it.end_of_buffer = eob;
      pending_bytes.push_back(it);
   endtask

   // A well-formed buffer: start_new on the first byte, end_of_buffer on the last
   task automatic queue_buffer(input int len);
      for (int i = 0; i < len; i++)
         send(BYTE_W'($urandom_range(255)), i == 0, i == len - 1);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_ch.index <= idx;
      csr_ch.data  <= val[CSR_DAT_W-1:0];
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_SAMPLE_MODE: cfg_mode   = val[MODE_W-1:0];
         CSR_Q_BOUND:     cfg_bound  = val & 32'h1FFFF;
         CSR_COEF_TARGET: cfg_target = val & 32'h7FF;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Sender pauses until every item is taken and every result is back
   task automatic drain_results();
      while (pending_bytes.size() != 0 || req_offered) @(posedge clock);
      while (coef_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int queued;
      int len;
      req_ch.valid         = 1'b0;
      req_ch.rand_byte     = '0;
      req_ch.start_new     = 1'b0;
      req_ch.end_of_buffer = 1'b0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = '0;
      csr_ch.data          = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      recv_idle_pct = 76;

      // Eta one at reset settings: all zeros, all -1, all +1, rejected byte with end
      send(8'd0, 1'b1, 1'b0);
      send(8'd242, 1'b0, 1'b0);
      send(8'd121, 1'b0, 1'b0);
      send(8'd243, 1'b0, 1'b1);
      drain_results();

      // Uniform: largest value accepted at the full bound, zero pair
      write_reg(CSR_SAMPLE_MODE, MODE_UNIFORM);
      send(8'hFF, 1'b1, 1'b0);
      send(8'hFF, 1'b0, 1'b0);
      send(8'h00, 1'b0, 1'b0);
      send(8'h00, 1'b0, 1'b0);
      drain_results();

      // Bound edge, then an unpaired byte dropped at end of buffer
      write_reg(CSR_Q_BOUND, 17'h01000);
      send(8'hFF, 1'b0, 1'b0);
      send(8'h0F, 1'b0, 1'b0);
      send(8'h00, 1'b0, 1'b0);
      send(8'h10, 1'b0, 1'b0);
      send(8'h55, 1'b0, 1'b1);
      drain_results();

      // Zero bound rejects everything
      write_reg(CSR_Q_BOUND, 0);
      send(8'h00, 1'b1, 1'b0);
      send(8'h00, 1'b0, 1'b1);
      drain_results();

      // Eta two with a tiny target: target reached mid-byte, then bytes ignored
      write_reg(CSR_SAMPLE_MODE, MODE_ETA2);
      write_reg(CSR_COEF_TARGET, 3);
      send(8'h00, 1'b1, 1'b0);
      send(8'hF4, 1'b0, 1'b0);
      send(8'h4F, 1'b0, 1'b1);
      drain_results();

      // Target above the maximum; rejected nibbles and every value
      write_reg(CSR_COEF_TARGET, 2047);
      send(8'hFF, 1'b1, 1'b0);
      send(8'h4F, 1'b0, 1'b0);
      send(8'h32, 1'b0, 1'b0);
      send(8'h51, 1'b0, 1'b0);
      send(8'hE9, 1'b0, 1'b1);
      drain_results();

      // Zero target: status only
      write_reg(CSR_COEF_TARGET, 0);
      send(8'h12, 1'b1, 1'b1);
      drain_results();

      // Unused mode consumes bytes silently
      write_reg(CSR_SAMPLE_MODE, MODE_UNUSED);
      write_reg(CSR_COEF_TARGET, 256);
      send(8'h12, 1'b1, 1'b0);
      send(8'h34, 1'b0, 1'b1);

      // Random phases: mostly whole buffers, some loose bytes
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         if (phase < 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 76;
         end else if (phase < 6) begin
            send_idle_pct = 76;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_reg(CSR_SAMPLE_MODE, phase_mode[phase]);
         write_reg(CSR_Q_BOUND, phase_bound[phase]);
         write_reg(CSR_COEF_TARGET, phase_target[phase]);
         // long receiver hold-off while the sender keeps offering
         if (phase == PHASES - 2) begin
            @(posedge clock);
            stall_cycles = 0;
            stall_armed  = 1'b1;
         end
         queued = 0;
         while (queued < PHASE_ITEMS) begin
            if ($urandom_range(7) == 0) begin
               send(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
               queued++;
            end else begin
               len = $urandom_range(1, 24);
               queue_buffer(len);
               queued += len;
            end
         end
      end
      drain_results();

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
